FILE: rtl/hpse_pkg.sv
`timescale 1ns / 1ps

package hpse_pkg;

    // Request operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Result kinds
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_BYTE   = 1'b1;

    // NAL unit types of the parameter sets
    localparam logic [5:0] NAL_TYPE_MASK = 6'h3F;
    localparam logic [5:0] NAL_VPS       = 6'd32;
    localparam logic [5:0] NAL_SPS       = 6'd33;
    localparam logic [5:0] NAL_PPS       = 6'd34;

    // Store geometry that does not depend on the buffer size
    localparam int SLOT_COUNT = 3;
    localparam int BANKS      = 4;
    localparam int PREFIX_LEN = 4;

    // Start code put in front of every set on readout
    localparam logic [7:0] PREFIX [PREFIX_LEN] = '{8'h00, 8'h00, 8'h00, 8'h01};

    // One result as it leaves the core
    typedef struct packed {
        logic       result_kind;
        logic [7:0] out_byte;
        logic       out_last;
        logic       params_ready;
        logic       overflow;
        logic       from_store;
    } hpse_result_t;

endpackage

FILE: rtl/hevc_parameter_set_extractor.sv
`timescale 1ns / 1ps
// A request passes the input register, then the result register; banked RAM
// reads are registered alongside the result register.
// Throughput: one request per cycle; a waiting result holds back the next request
// that gives one. The store takes up to four bytes a cycle.
// Reset (aresetn, synchronous, active low) clears scanner, capture flags,
// lengths and handshake state at once; stored bytes are not cleared.
module hevc_parameter_set_extractor #(
    parameter int MAX_SET_BYTES = 512
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_operation,
    input  logic [7:0] s_data_byte,
    input  logic       s_first_of_unit,
    input  logic       s_last_of_unit,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_result_kind,
    output logic [7:0] m_out_byte,
    output logic       m_out_last,
    output logic       m_params_ready,
    output logic       m_overflow
);
    import hpse_pkg::*;

    localparam int WORDS_PER_SLOT = (MAX_SET_BYTES + BANKS - 1) / BANKS;
    localparam int BANK_DEPTH     = SLOT_COUNT * WORDS_PER_SLOT;
    localparam int ADDR_W         = $clog2(BANK_DEPTH);

    logic         in_valid_reg;
    logic         op_reg;
    logic [7:0]   byte_reg;
    logic         first_reg;
    logic         last_reg;
    logic         fire;
    logic         produces;
    logic         has_result;
    hpse_result_t result;
    hpse_result_t res_reg;
    logic         m_valid_reg;

    logic [BANKS-1:0]             wr_en;
    logic [BANKS-1:0][ADDR_W-1:0] wr_addr;
    logic [BANKS-1:0][7:0]        wr_data;
    logic                         rd_en;
    logic [1:0]                   rd_bank;
    logic [ADDR_W-1:0]            rd_addr;
    logic [7:0]                   rd_data;

    // Advance the held request when it gives no result or its result has room
    assign produces = (op_reg == OP_READ) || last_reg;
    assign fire     = in_valid_reg && (!produces || !m_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || fire;

    // Hold the accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg    <= s_operation;
            byte_reg  <= s_data_byte;
            first_reg <= s_first_of_unit;
            last_reg  <= s_last_of_unit;
        end
    end

    hpse_core #(
        .MAX_SET_BYTES (MAX_SET_BYTES),
        .ADDR_W        (ADDR_W)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (fire),
        .operation     (op_reg),
        .data_byte     (byte_reg),
        .first_of_unit (first_reg),
        .last_of_unit  (last_reg),
        .has_result    (has_result),
        .result        (result),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_en         (rd_en),
        .rd_bank       (rd_bank),
        .rd_addr       (rd_addr)
    );

    hpse_store #(
        .BANK_DEPTH (BANK_DEPTH),
        .ADDR_W     (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_bank (rd_bank),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Hold the result until the consumer takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire && has_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && has_result) begin
            res_reg <= result;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_kind  = res_reg.result_kind;
    assign m_out_byte     = res_reg.from_store ? rd_data : res_reg.out_byte;
    assign m_out_last     = res_reg.out_last;
    assign m_params_ready = res_reg.params_ready;
    assign m_overflow     = res_reg.overflow;

endmodule

FILE: rtl/hpse_store.sv
`timescale 1ns / 1ps

module hpse_store #(
    parameter int BANK_DEPTH = 384,
    parameter int ADDR_W     = 9
) (
    input  logic                                    aclk,
    input  logic [hpse_pkg::BANKS-1:0]              wr_en,
    input  logic [hpse_pkg::BANKS-1:0][ADDR_W-1:0]  wr_addr,
    input  logic [hpse_pkg::BANKS-1:0][7:0]         wr_data,
    input  logic                                    rd_en,
    input  logic [1:0]                              rd_bank,
    input  logic [ADDR_W-1:0]                       rd_addr,
    output logic [7:0]                              rd_data
);
    import hpse_pkg::*;

    logic [7:0] mem [BANKS][BANK_DEPTH];
    logic [7:0] rd_data_reg;

    // Write up to one byte per bank; consecutive bytes land in distinct banks
    always_ff @(posedge aclk) begin
        for (int j = 0; j < BANKS; j++) begin
            if (wr_en[j]) begin
                mem[j][wr_addr[j]] <= wr_data[j];
            end
        end
    end

    // Read one byte and hold it until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_bank][rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/hpse_core.sv
`timescale 1ns / 1ps

module hpse_core #(
    parameter int MAX_SET_BYTES = 512,
    parameter int ADDR_W        = 9
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    fire,
    input  logic                                    operation,
    input  logic [7:0]                              data_byte,
    input  logic                                    first_of_unit,
    input  logic                                    last_of_unit,
    output logic                                    has_result,
    output hpse_pkg::hpse_result_t                  result,
    output logic [hpse_pkg::BANKS-1:0]              wr_en,
    output logic [hpse_pkg::BANKS-1:0][ADDR_W-1:0]  wr_addr,
    output logic [hpse_pkg::BANKS-1:0][7:0]         wr_data,
    output logic                                    rd_en,
    output logic [1:0]                              rd_bank,
    output logic [ADDR_W-1:0]                       rd_addr
);
    import hpse_pkg::*;

    localparam int WORDS_PER_SLOT = (MAX_SET_BYTES + BANKS - 1) / BANKS;
    localparam int LEN_W          = $clog2(MAX_SET_BYTES + 1);
    localparam int OFF_W          = $clog2(MAX_SET_BYTES + PREFIX_LEN);

    typedef enum logic [1:0] {
        PH_SEEK,
        PH_HEADER,
        PH_BODY
    } phase_t;

    logic [23:0]      recent_reg, recent_next;
    logic [2:0]       noff_reg, noff_next;
    phase_t           phase_reg, phase_next;
    logic [1:0]       tgt_reg, tgt_next;
    logic [LEN_W-1:0] len_reg [SLOT_COUNT];
    logic [LEN_W-1:0] len_next [SLOT_COUNT];
    logic [2:0]       found_reg, found_next;
    logic             frozen_reg, frozen_next;
    logic             ovf_reg, ovf_next;
    logic [1:0]       seg_reg, seg_next;
    logic [OFF_W-1:0] off_reg, off_next;

    // Base word of a slot inside each bank
    function automatic logic [ADDR_W-1:0] slot_base(input logic [1:0] slot);
        return ADDR_W'(slot) * ADDR_W'(WORDS_PER_SLOT);
    endfunction

    // Next state, store writes, store read and result for one request
    always_comb begin
        logic [7:0]       r0, r1, r2;
        logic [5:0]       nal_type;
        logic [1:0]       slot;
        logic [1:0]       bank;
        logic [3:0]       q_en;
        logic [7:0]       q_data [4];
        logic             fin;
        logic             seg_end;
        logic             is_last;
        logic [OFF_W-1:0] rel;

        recent_next = recent_reg;
        noff_next   = noff_reg;
        phase_next  = phase_reg;
        tgt_next    = tgt_reg;
        for (int s = 0; s < SLOT_COUNT; s++) begin
            len_next[s] = len_reg[s];
        end
        found_next  = found_reg;
        frozen_next = frozen_reg;
        ovf_next    = ovf_reg;
        seg_next    = seg_reg;
        off_next    = off_reg;

        r0       = recent_reg[7:0];
        r1       = recent_reg[15:8];
        r2       = recent_reg[23:16];
        nal_type = data_byte[6:1] & NAL_TYPE_MASK;
        slot     = '0;
        bank     = '0;
        q_en     = '0;
        for (int k = 0; k < 4; k++) begin
            q_data[k] = '0;
        end
        fin     = 1'b0;
        seg_end = 1'b0;
        is_last = 1'b0;
        rel     = '0;

        wr_en      = '0;
        wr_addr    = '0;
        wr_data    = '0;
        rd_en      = 1'b0;
        rd_bank    = '0;
        rd_addr    = '0;
        has_result = 1'b0;
        result     = '0;

        if (fire) begin
            if (operation == OP_READ) begin
                // Stream prefix and stored bytes of the frozen sets; before that, a read gives only flags
                has_result          = 1'b1;
                result.result_kind  = KIND_BYTE;
                result.params_ready = frozen_reg;
                result.overflow     = ovf_reg;
                if (frozen_reg) begin
                    if (off_reg < OFF_W'(PREFIX_LEN)) begin
                        result.out_byte = PREFIX[off_reg[1:0]];
                    end else begin
                        rel               = off_reg - OFF_W'(PREFIX_LEN);
                        rd_en             = 1'b1;
                        rd_bank           = rel[1:0];
                        rd_addr           = slot_base(seg_reg) + ADDR_W'(rel >> 2);
                        result.from_store = 1'b1;
                    end
                    seg_end = (off_reg == OFF_W'(len_reg[seg_reg]) + OFF_W'(PREFIX_LEN - 1));
                    is_last = seg_end && (seg_reg == 2'(SLOT_COUNT - 1));
                    result.out_last = is_last;
                    if (seg_end) begin
                        off_next = '0;
                        seg_next = is_last ? 2'd0 : seg_reg + 2'd1;
                    end else begin
                        off_next = off_reg + OFF_W'(1);
                    end
                end
            end else begin
                // Drop the per-unit capture at the start of a unit
                if (first_of_unit && !frozen_reg) begin
                    recent_next = '0;
                    noff_next   = '0;
                    phase_next  = PH_SEEK;
                    tgt_next    = '0;
                    found_next  = '0;
                    for (int s = 0; s < SLOT_COUNT; s++) begin
                        len_next[s] = '0;
                    end
                    r0 = '0;
                    r1 = '0;
                    r2 = '0;
                end

                // Advance the start-code scanner
                if (!frozen_reg) begin
                    unique case (phase_next)
                        PH_SEEK: begin
                            if (data_byte == 8'd1 && noff_next >= 3'd2 &&
                                r0 == 8'd0 && r1 == 8'd0) begin
                                phase_next  = PH_HEADER;
                                noff_next   = '0;
                                recent_next = '0;
                            end else begin
                                recent_next = {recent_next[15:0], data_byte};
                                if (noff_next < 3'd3) begin
                                    noff_next = noff_next + 3'd1;
                                end
                            end
                        end
                        PH_HEADER: begin
                            tgt_next = '0;
                            if (nal_type >= NAL_VPS && nal_type <= NAL_PPS) begin
                                slot = 2'(nal_type - NAL_VPS);
                                if (!found_next[slot]) begin
                                    tgt_next       = slot + 2'd1;
                                    len_next[slot] = '0;
                                end
                            end
                            recent_next = {16'd0, data_byte};
                            noff_next   = 3'd1;
                            phase_next  = PH_BODY;
                        end
                        PH_BODY: begin
                            if (data_byte == 8'd1 && noff_next >= 3'd4 &&
                                r0 == 8'd0 && r1 == 8'd0) begin
                                // Keep the byte before the zeros unless it is a
                                // leading zero of a four-byte start code
                                q_en[0]     = !(noff_next >= 3'd5 && r2 == 8'd0);
                                q_data[0]   = r2;
                                fin         = 1'b1;
                                phase_next  = PH_HEADER;
                                noff_next   = '0;
                                recent_next = '0;
                            end else begin
                                q_en[0]     = (noff_next >= 3'd3);
                                q_data[0]   = r2;
                                recent_next = {recent_next[15:0], data_byte};
                                if (noff_next != 3'd7) begin
                                    noff_next = noff_next + 3'd1;
                                end
                            end
                        end
                        default: begin
                            phase_next = PH_SEEK;
                        end
                    endcase
                end

                // Flush held-back bytes into the open set at the end of a unit
                if (last_of_unit && !frozen_reg && phase_next == PH_BODY) begin
                    q_en[1]   = (noff_next >= 3'd3);
                    q_data[1] = recent_next[23:16];
                    q_en[2]   = (noff_next >= 3'd2);
                    q_data[2] = recent_next[15:8];
                    q_en[3]   = (noff_next >= 3'd1);
                    q_data[3] = recent_next[7:0];
                    fin       = 1'b1;
                end

                // Store queued bytes in order; a full slot drops the set
                for (int k = 0; k < 4; k++) begin
                    if (q_en[k] && tgt_next != 2'd0) begin
                        slot = tgt_next - 2'd1;
                        if (len_next[slot] < LEN_W'(MAX_SET_BYTES)) begin
                            bank          = len_next[slot][1:0];
                            wr_en[bank]   = 1'b1;
                            wr_addr[bank] = slot_base(slot) + ADDR_W'(len_next[slot] >> 2);
                            wr_data[bank] = q_data[k];
                            len_next[slot] = len_next[slot] + LEN_W'(1);
                        end else begin
                            len_next[slot] = '0;
                            tgt_next       = '0;
                            ovf_next       = 1'b1;
                        end
                    end
                end

                // Close the set; freeze once all three are in
                if (fin) begin
                    if (tgt_next != 2'd0) begin
                        found_next[tgt_next - 2'd1] = 1'b1;
                        if (found_next == 3'b111) begin
                            frozen_next = 1'b1;
                            seg_next    = '0;
                            off_next    = '0;
                        end
                    end
                    tgt_next = '0;
                end

                // Report status and clear the unit
                if (last_of_unit) begin
                    if (!frozen_next) begin
                        recent_next = '0;
                        noff_next   = '0;
                        phase_next  = PH_SEEK;
                        tgt_next    = '0;
                        found_next  = '0;
                        for (int s = 0; s < SLOT_COUNT; s++) begin
                            len_next[s] = '0;
                        end
                    end
                    has_result          = 1'b1;
                    result.result_kind  = KIND_STATUS;
                    result.params_ready = frozen_next;
                    result.overflow     = ovf_next;
                end
            end
        end
    end

    // Hold scanner, capture and readout state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recent_reg <= '0;
            noff_reg   <= '0;
            phase_reg  <= PH_SEEK;
            tgt_reg    <= '0;
            for (int s = 0; s < SLOT_COUNT; s++) begin
                len_reg[s] <= '0;
            end
            found_reg  <= '0;
            frozen_reg <= 1'b0;
            ovf_reg    <= 1'b0;
            seg_reg    <= '0;
            off_reg    <= '0;
        end else begin
            recent_reg <= recent_next;
            noff_reg   <= noff_next;
            phase_reg  <= phase_next;
            tgt_reg    <= tgt_next;
            for (int s = 0; s < SLOT_COUNT; s++) begin
                len_reg[s] <= len_next[s];
            end
            found_reg  <= found_next;
            frozen_reg <= frozen_next;
            ovf_reg    <= ovf_next;
            seg_reg    <= seg_next;
            off_reg    <= off_next;
        end
    end

endmodule
